// ===== hdl/ecr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

    // Elevation sample width and the signed width used for band compares.
    localparam int ELEV_BITS   = 16;
    localparam int CMP_BITS    = ELEV_BITS + 1;

    // Band bookkeeping.
    localparam int NUM_BANDS_RAW = 5;
    localparam int NUM_BANDS_ENH = 8;
    localparam int NUM_BANDS_MAX = 8;
    localparam int IDX_BITS      = 3;

    // Offset within a band (largest span is 5000 m).
    localparam int OFF_BITS    = 13;
    // Divisor of the rounding quotient is twice the span.
    localparam int DIV_BITS    = OFF_BITS + 1;
    // Biased numerator 2*d*off + 513*span stays below 2^23.
    localparam int X_BITS      = 23;
    // Reciprocal of the divisor scaled by 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_BITS  = 14;
    localparam int P_BITS      = X_BITS + RECIP_BITS;
    // Biased quotient stays below 512.
    localparam int Q_BITS      = 10;
    localparam int PROD_BITS   = Q_BITS + DIV_BITS;
    // Width of the final sum a + q + carry.
    localparam int SUM_BITS    = 12;
    localparam int NUM_CH      = 3;

    // Ramp mode codes.
    localparam logic MODE_RAW = 1'b0;
    localparam logic MODE_ENH = 1'b1;

    typedef logic signed [ELEV_BITS-1:0] t_elev;
    typedef logic [NUM_CH-1:0][7:0]      t_rgb;

    // One band of the ramp: start, span, scaled reciprocal of 2*span,
    // start color and color step per channel.
    typedef struct packed {
        logic signed [CMP_BITS-1:0]   lo;
        logic [OFF_BITS-1:0]          span;
        logic [RECIP_BITS-1:0]        recip;
        logic [NUM_CH-1:0][7:0]       a;
        logic [NUM_CH-1:0][8:0]       d;
    } t_band;

    // Item passed from the band selector to the channel mixer.
    typedef struct packed {
        logic                  mode;
        logic [IDX_BITS-1:0]   idx;
        logic [OFF_BITS-1:0]   off;
    } t_band_item;

    function automatic t_band mk_band(input int lo, input int span, input int recip,
                                      input int a0, input int a1, input int a2,
                                      input int b0, input int b1, input int b2);
        t_band r;
        r.lo    = CMP_BITS'(lo);
        r.span  = OFF_BITS'(span);
        r.recip = RECIP_BITS'(recip);
        r.a[0]  = 8'(a0);
        r.a[1]  = 8'(a1);
        r.a[2]  = 8'(a2);
        r.d[0]  = 9'(b0 - a0);
        r.d[1]  = 9'(b1 - a1);
        r.d[2]  = 9'(b2 - a2);
        return r;
    endfunction

    // Band table. The reciprocal is floor(2^23 / (2 * span)).
    function automatic t_band band_info(input logic mode, input logic [IDX_BITS-1:0] idx);
        t_band r;
        r = mk_band(5000, 3000, 1398, 123, 90, 60, 245, 245, 245);
        if (mode == MODE_ENH) begin
            case (idx)
                3'd0:    r = mk_band(-6000, 5000,  838,   9,  34,  90,  32,  94, 160);
                3'd1:    r = mk_band(-1000, 1000, 4194,  32,  94, 160,  95, 168, 209);
                3'd2:    r = mk_band(    0,  500, 8388,  92, 146,  82, 126, 165, 102);
                3'd3:    r = mk_band(  500,  500, 8388, 126, 165, 102, 162, 177, 120);
                3'd4:    r = mk_band( 1000, 1000, 4194, 162, 177, 120, 188, 175, 124);
                3'd5:    r = mk_band( 2000, 2000, 2097, 188, 175, 124, 153, 127,  91);
                3'd6:    r = mk_band( 4000, 2500, 1677, 153, 127,  91, 121,  91,  68);
                default: r = mk_band( 6500, 2000, 2097, 121,  91,  68, 245, 245, 245);
            endcase
        end else begin
            case (idx)
                3'd0:    r = mk_band(-6000, 5000,  838,   7,  36,  97,  36, 102, 170);
                3'd1:    r = mk_band(-1000, 1000, 4194,  36, 102, 170, 108, 179, 214);
                3'd2:    r = mk_band(    0, 2000, 2097,  76, 134,  68, 171, 145,  86);
                3'd3:    r = mk_band( 2000, 3000, 1398, 171, 145,  86, 123,  90,  60);
                default: r = mk_band( 5000, 3000, 1398, 123,  90,  60, 245, 245, 245);
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ecr_elev_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ecr_elev_if;
    import ecr_pkg::*;

    logic  valid;
    logic  ready;
    t_elev elevation_m;

    modport source (output valid, output elevation_m, input ready);
    modport sink   (input valid, input elevation_m, output ready);
endinterface

`default_nettype wire

// ===== hdl/ecr_color_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ecr_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/ecr_band_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecr_band_sel (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_mode,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  ecr_pkg::t_elev           i_elev,
    output logic                     o_valid,
    input  wire                      i_ready,
    output ecr_pkg::t_band_item      o_item
);
    import ecr_pkg::*;

    logic                       r_v1;
    logic                       r_v2;
    logic signed [CMP_BITS-1:0] r_s1_e;
    logic                       r_s1_mode;
    logic [IDX_BITS-1:0]        r_s1_idx;
    t_band_item                 r_s2_item;

    logic                       adv1;
    logic                       adv2;
    logic signed [CMP_BITS-1:0] e_ext;
    logic [IDX_BITS-1:0]        n_idx;
    logic                       found;
    int                         nb;
    t_band                      bd_cmp;
    t_band                      bd2;
    logic signed [CMP_BITS-1:0] thr;
    logic signed [CMP_BITS:0]   diff;
    logic [OFF_BITS-1:0]        n_off;

    // Each stage moves on when it is empty or the next one moves.
    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // Stage 1: find the first band whose end lies above the sample, else the last band.
    always_comb begin
        e_ext  = CMP_BITS'(i_elev);
        nb     = (i_mode == MODE_ENH) ? NUM_BANDS_ENH : NUM_BANDS_RAW;
        n_idx  = IDX_BITS'(nb - 1);
        found  = 1'b0;
        bd_cmp = band_info(i_mode, '0);
        thr    = '0;
        for (int i = 0; i < NUM_BANDS_MAX - 1; i++) begin
            bd_cmp = band_info(i_mode, IDX_BITS'(i));
            thr    = bd_cmp.lo + CMP_BITS'($signed({1'b0, bd_cmp.span}));
            if (!found && (i < nb - 1) && (e_ext < thr)) begin
                n_idx = IDX_BITS'(i);
                found = 1'b1;
            end
        end
    end

    // Stage 2: offset into the band, clamped to 0..span.
    always_comb begin
        bd2  = band_info(r_s1_mode, r_s1_idx);
        diff = (CMP_BITS+1)'(r_s1_e) - (CMP_BITS+1)'(bd2.lo);
        if (diff < 0) begin
            n_off = '0;
        end else if (diff > (CMP_BITS+1)'($signed({1'b0, bd2.span}))) begin
            n_off = bd2.span;
        end else begin
            n_off = diff[OFF_BITS-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_e    <= e_ext;
            r_s1_mode <= i_mode;
            r_s1_idx  <= n_idx;
        end
        if (adv2) begin
            r_s2_item.mode <= r_s1_mode;
            r_s2_item.idx  <= r_s1_idx;
            r_s2_item.off  <= n_off;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2_item;

    // The clamped offset never exceeds the span of its band.
    a_off_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2_item.off <= band_info(r_s2_item.mode, r_s2_item.idx).span))
        else $error("band offset beyond span");

    // The band index stays inside the table of the selected mode.
    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_s2_item.mode == MODE_ENH) ||
                  (r_s2_item.idx < IDX_BITS'(NUM_BANDS_RAW))))
        else $error("band index outside raw table");

    // A stalled first stage keeps its item.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !adv2) |=> r_v1)
        else $error("stage 1 item lost under stall");

endmodule

`default_nettype wire

// ===== hdl/ecr_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecr_mix (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  ecr_pkg::t_band_item      i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output ecr_pkg::t_rgb            o_rgb
);
    import ecr_pkg::*;

    logic r_v3;
    logic r_v4;
    logic r_v5;
    logic r_v6;
    logic adv3;
    logic adv4;
    logic adv5;
    logic adv6;

    logic                               r_s3_mode;
    logic [IDX_BITS-1:0]                r_s3_idx;
    logic [NUM_CH-1:0][X_BITS-1:0]      r_s3_x;
    logic                               r_s4_mode;
    logic [IDX_BITS-1:0]                r_s4_idx;
    logic [NUM_CH-1:0][X_BITS-1:0]      r_s4_x;
    logic [NUM_CH-1:0][Q_BITS-1:0]      r_s4_q;
    logic                               r_s5_mode;
    logic [IDX_BITS-1:0]                r_s5_idx;
    logic [NUM_CH-1:0][X_BITS-1:0]      r_s5_x;
    logic [NUM_CH-1:0][Q_BITS-1:0]      r_s5_q;
    logic [NUM_CH-1:0][PROD_BITS-1:0]   r_s5_prod;
    t_rgb                               r_rgb;

    t_band                              bd3;
    t_band                              bd4;
    t_band                              bd5;
    t_band                              bd6;
    logic [X_BITS-1:0]                  bias;
    logic signed [X_BITS-2:0]           step;
    logic signed [X_BITS+1:0]           xsum;
    logic [NUM_CH-1:0][X_BITS-1:0]      n_x;
    logic [P_BITS-1:0]                  pq;
    logic [NUM_CH-1:0][Q_BITS-1:0]      n_q;
    logic [DIV_BITS-1:0]                dv5;
    logic [DIV_BITS-1:0]                dv6;
    logic [NUM_CH-1:0][PROD_BITS-1:0]   n_prod;
    logic [NUM_CH-1:0][PROD_BITS-1:0]   resid;
    logic [NUM_CH-1:0][SUM_BITS-1:0]    usum;
    t_rgb                               n_rgb;

    // Each stage moves on when it is empty or the next one moves.
    assign adv6    = !r_v6 || i_ready;
    assign adv5    = !r_v5 || adv6;
    assign adv4    = !r_v4 || adv5;
    assign adv3    = !r_v3 || adv4;
    assign o_ready = adv3;

    // Stage 3: biased numerator 2*d*off + 513*span, always positive.
    always_comb begin
        bd3  = band_info(i_item.mode, i_item.idx);
        bias = (X_BITS'(bd3.span) << 9) + X_BITS'(bd3.span);
        step = '0;
        xsum = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            step   = $signed(bd3.d[c]) * $signed({1'b0, i_item.off});
            xsum   = ((X_BITS+2)'(step) <<< 1) + $signed({2'b00, bias});
            n_x[c] = xsum[X_BITS-1:0];
        end
    end

    // Stage 4: quotient estimate by the scaled reciprocal; at most one low.
    always_comb begin
        bd4 = band_info(r_s3_mode, r_s3_idx);
        pq  = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            pq     = P_BITS'(r_s3_x[c]) * P_BITS'(bd4.recip);
            n_q[c] = pq[RECIP_SHIFT+Q_BITS-1:RECIP_SHIFT];
        end
    end

    // Stage 5: multiply the estimate back by the divisor 2*span.
    always_comb begin
        bd5 = band_info(r_s4_mode, r_s4_idx);
        dv5 = {bd5.span, 1'b0};
        for (int c = 0; c < NUM_CH; c++) begin
            n_prod[c] = PROD_BITS'(r_s4_q[c]) * PROD_BITS'(dv5);
        end
    end

    // Stage 6: correct the estimate, remove the bias, add the start color and clamp to 0..255.
    always_comb begin
        bd6 = band_info(r_s5_mode, r_s5_idx);
        dv6 = {bd6.span, 1'b0};
        for (int c = 0; c < NUM_CH; c++) begin
            resid[c] = PROD_BITS'(r_s5_x[c]) - r_s5_prod[c];
            usum[c]  = SUM_BITS'(bd6.a[c]) + SUM_BITS'(r_s5_q[c])
                     + SUM_BITS'(resid[c] >= PROD_BITS'(dv6));
            if (usum[c] < SUM_BITS'(256)) begin
                n_rgb[c] = 8'd0;
            end else if (usum[c] > SUM_BITS'(511)) begin
                n_rgb[c] = 8'd255;
            end else begin
                n_rgb[c] = usum[c][7:0];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (adv3) r_v3 <= i_valid;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
            if (adv6) r_v6 <= r_v5;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_mode <= i_item.mode;
            r_s3_idx  <= i_item.idx;
            r_s3_x    <= n_x;
        end
        if (adv4) begin
            r_s4_mode <= r_s3_mode;
            r_s4_idx  <= r_s3_idx;
            r_s4_x    <= r_s3_x;
            r_s4_q    <= n_q;
        end
        if (adv5) begin
            r_s5_mode <= r_s4_mode;
            r_s5_idx  <= r_s4_idx;
            r_s5_x    <= r_s4_x;
            r_s5_q    <= r_s4_q;
            r_s5_prod <= n_prod;
        end
        if (adv6) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_v6;
    assign o_rgb   = r_rgb;

    // The reciprocal estimate is never more than one below the true quotient.
    a_resid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> ((resid[0] < PROD_BITS'({dv6, 1'b0})) &&
                  (resid[1] < PROD_BITS'({dv6, 1'b0})) &&
                  (resid[2] < PROD_BITS'({dv6, 1'b0}))))
        else $error("quotient estimate off by more than one");

    // The interpolated value already lies in 0..255 before the clamp.
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> ((usum[0] >= SUM_BITS'(256)) && (usum[0] <= SUM_BITS'(511)) &&
                  (usum[1] >= SUM_BITS'(256)) && (usum[1] <= SUM_BITS'(511)) &&
                  (usum[2] >= SUM_BITS'(256)) && (usum[2] <= SUM_BITS'(511))))
        else $error("channel value outside color range");

    // A stalled middle stage keeps its item.
    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !adv5) |=> r_v4)
        else $error("stage 4 item lost under stall");

endmodule

`default_nettype wire

// ===== hdl/elevation_color_ramp.sv =====
// Throughput: one elevation sample per cycle unless the output stalls; six register
// stages (band compare, offset clamp, lane multiply, reciprocal multiply, check multiply,
// correction).
// Each stage has its own valid bit, so bubbles are filled while the output stalls.
// Reset (synchronous, active low) clears all valid bits and sets ramp_mode to raw.
`timescale 1ns / 1ps
`default_nettype none

module elevation_color_ramp (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_data,
    ecr_elev_if.sink     i_elev,
    ecr_color_if.source  o_color
);
    import ecr_pkg::*;

    logic       r_ramp_mode;
    logic       sel_valid;
    logic       sel_ready;
    t_band_item sel_item;
    t_rgb       rgb;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_mode <= MODE_RAW;
        end else if (i_cfg_we) begin
            r_ramp_mode <= i_cfg_data;
        end
    end

    // Band selection and offset.
    ecr_band_sel u_band_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_ramp_mode),
        .i_valid (i_elev.valid),
        .o_ready (i_elev.ready),
        .i_elev  (i_elev.elevation_m),
        .o_valid (sel_valid),
        .i_ready (sel_ready),
        .o_item  (sel_item)
    );

    // Channel interpolation and rounding.
    ecr_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .o_ready (sel_ready),
        .i_item  (sel_item),
        .o_valid (o_color.valid),
        .i_ready (o_color.ready),
        .o_rgb   (rgb)
    );

    assign o_color.red   = rgb[0];
    assign o_color.green = rgb[1];
    assign o_color.blue  = rgb[2];

endmodule

`default_nettype wire
